// ===== hw/rtl/blx_pkg.sv =====
// Package for the byte stream lexer: item types, token kind codes and constants.
// Used by blx_front, blx_queue, blx_back, byte_stream_lexer and blx_checker.
// Depends on nothing.
package blx_pkg;

  localparam logic [3:0] KInt     = 4'd0;
  localparam logic [3:0] KIdent   = 4'd1;
  localparam logic [3:0] KPlus    = 4'd2;
  localparam logic [3:0] KMinus   = 4'd3;
  localparam logic [3:0] KStar    = 4'd4;
  localparam logic [3:0] KSlash   = 4'd5;
  localparam logic [3:0] KLparen  = 4'd6;
  localparam logic [3:0] KRparen  = 4'd7;
  localparam logic [3:0] KAssign  = 4'd8;
  localparam logic [3:0] KNewline = 4'd9;
  localparam logic [3:0] KUnknown = 4'd10;
  localparam logic [3:0] KEof     = 4'd11;
  localparam logic [3:0] KText    = 4'd12;

  localparam logic [7:0]  MaxText = 8'd255;
  localparam logic [30:0] IntSat  = 31'h7FFF_FFFF;
  localparam int          QueueDepth = 4;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  char_code;
    logic [30:0] int_value;
    logic [7:0]  token_length;
    logic        value_overflow;
    logic        last;
  } out_item_t;

  // Work for the back end: an optional closed token, then an optional second result.
  typedef struct packed {
    logic        tok_valid;
    logic [3:0]  tok_kind;
    logic [30:0] tok_value;
    logic [7:0]  tok_length;
    logic        tok_overflow;
    logic        sec_valid;
    logic [3:0]  sec_kind;
    logic [7:0]  sec_char;
  } cmd_t;

endpackage

// ===== hw/rtl/byte_stream_lexer.sv =====
// Byte stream lexer, top level: front end, command queue and back end.
// Depends on blx_pkg, blx_front, blx_queue and blx_back.
//
// Usage:
//   The in_ channel takes one source byte per item, or an end-of-input mark.
//   The out_ channel delivers tokens and echoed text characters, up to two
//   result items per input item, with last set on the final one.
//   The command for an accepted input item is written into the queue and is
//   then loaded into the output register, which holds the first result item.
//   Input throughput is one item per cycle while the queue has room. The
//   back end sends one result per cycle while the receiver is ready, so items
//   that close a token and also produce a second result send two results, and
//   a long run of them is limited by that output port.
//   Spaces and tabs outside a token cause no result at all.
//   When the receiver stalls, the output register holds its item, the queue
//   fills, and in_ready falls once QUEUE_DEPTH commands are waiting.
//   Reset clears the token state, the queue and the output valid flag.
module byte_stream_lexer #(
  parameter int QUEUE_DEPTH = blx_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  blx_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output blx_pkg::out_item_t out_item
);

  logic          accept, push, pop, empty, full;
  blx_pkg::cmd_t push_cmd, head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  blx_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .push   (push),
    .cmd    (push_cmd)
  );

  blx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  blx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== hw/rtl/blx_front.sv =====
// Lexer front end: classifies each accepted byte, keeps the open token state and
// builds one command per item that causes results. Depends on blx_pkg.
module blx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  blx_pkg::in_item_t item,
  output logic              push,
  output blx_pkg::cmd_t     cmd
);

  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModeInt   = 2'd1;
  localparam logic [1:0] ModeIdent = 2'd2;

  logic [1:0]  lex_mode_r, lex_mode_nxt;
  logic [30:0] accum_value_r, accum_value_nxt;
  logic [7:0]  accum_length_r, accum_length_nxt;
  logic        accum_overflow_r, accum_overflow_nxt;

  logic [7:0]  c;
  logic        eoi, is_digit, is_alpha, is_word, is_space;
  logic        cont_int, cont_ident, keep, add_dig, add_len;
  logic [30:0] base_val;
  logic [7:0]  base_len;
  logic        base_ovf;
  logic [34:0] prod;
  logic [3:0]  single_kind;

  assign c        = item.byte_in;
  assign eoi      = item.end_of_input;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_word  = is_digit || is_alpha || (c == 8'h5F);
  assign is_space = (c == 8'h20) || (c == 8'h09);

  assign cont_int   = !eoi && (lex_mode_r == ModeInt) && is_digit;
  assign cont_ident = !eoi && (lex_mode_r == ModeIdent) && is_word;
  assign keep       = cont_int || cont_ident;
  assign add_dig    = !eoi && is_digit && (lex_mode_r != ModeIdent);
  assign add_len    = !eoi && is_word;

  assign base_val = keep ? accum_value_r : 31'd0;
  assign base_len = keep ? accum_length_r : 8'd0;
  assign base_ovf = keep ? accum_overflow_r : 1'b0;
  assign prod     = {1'b0, base_val, 3'b000} + {3'b000, base_val, 1'b0}
                  + {31'd0, c[3:0]};

  always_comb begin
    case (c)
      8'h2B:   single_kind = blx_pkg::KPlus;
      8'h2D:   single_kind = blx_pkg::KMinus;
      8'h2A:   single_kind = blx_pkg::KStar;
      8'h2F:   single_kind = blx_pkg::KSlash;
      8'h28:   single_kind = blx_pkg::KLparen;
      8'h29:   single_kind = blx_pkg::KRparen;
      8'h3D:   single_kind = blx_pkg::KAssign;
      8'h0A:   single_kind = blx_pkg::KNewline;
      default: single_kind = blx_pkg::KUnknown;
    endcase
  end

  always_comb begin
    accum_value_nxt    = base_val;
    accum_overflow_nxt = base_ovf;
    accum_length_nxt   = base_len;
    if (add_dig) begin
      if (prod > {4'd0, blx_pkg::IntSat}) begin
        accum_value_nxt    = blx_pkg::IntSat;
        accum_overflow_nxt = 1'b1;
      end else begin
        accum_value_nxt = prod[30:0];
      end
    end
    if (add_len && (base_len < blx_pkg::MaxText)) begin
      accum_length_nxt = base_len + 8'd1;
    end

    if (eoi) begin
      lex_mode_nxt = ModeIdle;
    end else if (keep) begin
      lex_mode_nxt = lex_mode_r;
    end else if (is_digit) begin
      lex_mode_nxt = ModeInt;
    end else if (is_word) begin
      lex_mode_nxt = ModeIdent;
    end else begin
      lex_mode_nxt = ModeIdle;
    end

    cmd.tok_valid    = !keep && (lex_mode_r != ModeIdle);
    cmd.tok_kind     = (lex_mode_r == ModeInt) ? blx_pkg::KInt : blx_pkg::KIdent;
    cmd.tok_value    = (lex_mode_r == ModeInt) ? accum_value_r : 31'd0;
    cmd.tok_length   = accum_length_r;
    cmd.tok_overflow = (lex_mode_r == ModeInt) && accum_overflow_r;

    cmd.sec_valid = eoi || !is_space;
    if (eoi) begin
      cmd.sec_kind = blx_pkg::KEof;
      cmd.sec_char = 8'd0;
    end else if (is_word) begin
      cmd.sec_kind = blx_pkg::KText;
      cmd.sec_char = c;
    end else begin
      cmd.sec_kind = single_kind;
      cmd.sec_char = c;
    end
  end

  assign push = accept && (cmd.tok_valid || cmd.sec_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_mode_r       <= ModeIdle;
      accum_value_r    <= 31'd0;
      accum_length_r   <= 8'd0;
      accum_overflow_r <= 1'b0;
    end else if (accept) begin
      lex_mode_r       <= lex_mode_nxt;
      accum_value_r    <= accum_value_nxt;
      accum_length_r   <= accum_length_nxt;
      accum_overflow_r <= accum_overflow_nxt;
    end
  end

endmodule

// ===== hw/rtl/blx_queue.sv =====
// Short command queue between the lexer front end and back end.
// Depends on blx_pkg for the command type.
module blx_queue #(
  parameter int DEPTH = blx_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  blx_pkg::cmd_t push_cmd,
  input  logic          pop,
  output blx_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  blx_pkg::cmd_t   mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == Full);
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/blx_back.sv =====
// Lexer back end: turns each queued command into one or two result items and
// holds them in the output register. Depends on blx_pkg.
module blx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  blx_pkg::cmd_t      head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output blx_pkg::out_item_t out_item
);

  logic               out_valid_r, out_valid_nxt;
  blx_pkg::out_item_t out_item_r, out_item_nxt;
  logic               phase_r, phase_nxt;
  logic               load, emit_tok;

  assign load     = !out_valid_r || out_ready;
  assign emit_tok = head.tok_valid && !phase_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    if (load && !empty) begin
      out_valid_nxt = 1'b1;
      if (emit_tok) begin
        out_item_nxt.kind           = head.tok_kind;
        out_item_nxt.char_code      = 8'd0;
        out_item_nxt.int_value      = head.tok_value;
        out_item_nxt.token_length   = head.tok_length;
        out_item_nxt.value_overflow = head.tok_overflow;
        out_item_nxt.last           = !head.sec_valid;
        phase_nxt                   = head.sec_valid;
        pop                         = !head.sec_valid;
      end else begin
        out_item_nxt.kind           = head.sec_kind;
        out_item_nxt.char_code      = head.sec_char;
        out_item_nxt.int_value      = 31'd0;
        out_item_nxt.token_length   = 8'd0;
        out_item_nxt.value_overflow = 1'b0;
        out_item_nxt.last           = 1'b1;
        phase_nxt                   = 1'b0;
        pop                         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hw/rtl/blx_checker.sv =====
// Port-level checks for the byte stream lexer, bound to the top level.
// Depends on blx_pkg and byte_stream_lexer.
module blx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input blx_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Stalled result item changed.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == blx_pkg::KEof) |-> out_item.last)
    else $error("End token is not the final result of its item.");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.value_overflow |->
      (out_item.kind == blx_pkg::KInt) && (out_item.int_value == blx_pkg::IntSat))
    else $error("Overflow flag without a saturated integer token.");

endmodule

bind byte_stream_lexer blx_checker u_blx_checker (.*);
